// ===== rtl/lghk_pkg.sv =====
// Shared types, constants and helpers of the LSH grid hash key unit.
package lghk_pkg;

  // Width of the key and of the modulus, multiplier and accumulators
  localparam int unsigned KeyBits = 32;
  // Width of a coordinate
  localparam int unsigned CoordBits = 48;
  // Dividend width of the bit-serial divider
  localparam int unsigned DivBits = 64;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_WINDOW_WIDTH = 3'd0,
    CFG_MODULUS      = 3'd1,
    CFG_MULTIPLIER   = 3'd2,
    CFG_HASH_COUNT   = 3'd3,
    CFG_DIMENSIONS   = 3'd4
  } cfg_index_e;

  // Request commands
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_COORD = 1'b1
  } command_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SUB,
    S_DIV_Q,
    S_MODQ,
    S_DIV_R,
    S_MUL,
    S_RED,
    S_DIV_P,
    S_ADD,
    S_KEY_RD,
    S_KEY_ACC,
    S_EMIT
  } state_e;

  // Bit spacing of the hash digits in the key: 32 / k
  function automatic logic [5:0] key_step(input logic [3:0] k);
    logic [5:0] s;
    case (k)
      4'd1:    s = 6'd32;
      4'd2:    s = 6'd16;
      4'd3:    s = 6'd10;
      4'd4:    s = 6'd8;
      4'd5:    s = 6'd6;
      4'd6:    s = 6'd5;
      4'd7:    s = 6'd4;
      4'd8:    s = 6'd4;
      4'd9:    s = 6'd3;
      4'd10:   s = 6'd3;
      4'd11:   s = 6'd2;
      4'd12:   s = 6'd2;
      4'd13:   s = 6'd2;
      4'd14:   s = 6'd2;
      4'd15:   s = 6'd2;
      default: s = 6'd32;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/lghk_div.sv =====
// Bit-serial restoring divider: 64-bit dividend, 32-bit divisor, one bit a cycle.
module lghk_div
  import lghk_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DivBits-1:0]   dividend_i,
  input  logic [KeyBits-1:0]   divisor_i,
  output logic                 done_o,
  output logic [DivBits-1:0]   quot_o,
  output logic [KeyBits-1:0]   rem_o
);

  localparam int unsigned CntW = $clog2(DivBits);

  logic [DivBits-1:0] dq_q, dq_d;
  logic [KeyBits-1:0] rem_q, rem_d;
  logic [KeyBits-1:0] dvs_q;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q, done_q;
  logic [KeyBits:0]   trial, diff;
  logic               fits;

  // One restoring step: shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, dq_q[DivBits-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
    rem_d = fits ? diff[KeyBits-1:0] : trial[KeyBits-1:0];
    dq_d  = {dq_q[DivBits-2:0], fits};
  end

  // Control: count the steps, pulse done after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivBits - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then advance one bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/lghk_acc_bank.sv =====
// Accumulator memory with per-entry valid bits; an invalid entry reads as zero.
module lghk_acc_bank
  import lghk_pkg::*;
#(
  parameter int unsigned AddrW = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               re_i,
  input  logic [AddrW-1:0]   raddr_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  logic [KeyBits-1:0] wdata_i,
  input  logic               clear_i,
  output logic [KeyBits-1:0] rdata_o
);

  localparam int unsigned Depth = 2 ** AddrW;

  logic [KeyBits-1:0] mem [Depth];
  logic [Depth-1:0]   vld_q;
  logic [KeyBits-1:0] rdata_q;
  logic               rvld_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Valid bits: set on write, drop all on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
      if (clear_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== rtl/lsh_grid_hash_key_unit.sv =====
// LSH grid hash key unit: loads a shift table, then hashes points one
// coordinate per request and emits a 32-bit key after the last coordinate.
// A load request is taken in the idle state. A coordinate request runs each
// of the k hashes in turn through one bit-serial 64-step divider that serves
// the grid divide, the digit reduction and the product reduction; with a zero
// modulus only the grid divide is run. After the final coordinate the key is
// assembled from the accumulator memory and passed to the output register.
// One request is worked on at a time; a finished key waits in an output
// register while the next request is taken.
module lsh_grid_hash_key_unit
  import lghk_pkg::*;
#(
  parameter int unsigned MAX_HASHES     = 8,
  parameter int unsigned MAX_DIMENSIONS = 1024,
  parameter int unsigned FRACTION_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [2:0]                  hash_index_i,
  input  logic [9:0]                  coord_index_i,
  input  logic [15:0]                 shift_value_i,
  input  logic signed [CoordBits-1:0] coordinate_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [KeyBits-1:0]          position_o
);

  localparam int unsigned HW   = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int unsigned DW   = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
  localparam int unsigned AW   = HW + DW;
  localparam int unsigned HCW  = $clog2(MAX_HASHES + 1);
  localparam int unsigned CW   = $clog2(MAX_DIMENSIONS + 1);
  localparam int unsigned NumW = CoordBits + 1;

  state_e state_q, state_d;

  // Configuration registers
  logic [15:0]        window_q;
  logic [KeyBits-1:0] modulus_q, mult_q;
  logic [3:0]         hcount_q;
  logic [10:0]        dims_q;

  // Point and per-hash working registers
  logic [CW-1:0]         count_q;
  logic [DW-1:0]         i_q;
  logic [HCW-1:0]        j_q;
  logic [3:0]            k_q;
  logic [CoordBits-1:0]  x_q;
  logic                  neg_q;
  logic [KeyBits-1:0]    a_q, hm_q, key_q, pos_q;
  logic [2*KeyBits-1:0]  prod_q;
  logic                  out_valid_q;

  // Shift table
  logic [15:0] shift_mem [2**AW];
  logic [15:0] shift_rd_q;

  // Sequencer outputs
  logic               accept, load_ok, shift_we, shift_re;
  logic               acc_re, acc_we, acc_clear, div_start, emit;
  logic [DivBits-1:0] div_dividend;
  logic [KeyBits-1:0] div_divisor;

  // Unit results
  logic               div_done;
  logic [DivBits-1:0] div_quot;
  logic [KeyBits-1:0] div_rem, acc_rd;

  // Derived values
  logic [15:0]           w_eff;
  logic [3:0]            k_eff;
  logic [CW-1:0]         d_eff;
  logic                  mod_zero, last_hash, last_coord;
  logic signed [NumW-1:0] num, t;
  logic [CoordBits-1:0]  u;
  logic [KeyBits:0]      sum;
  logic [KeyBits-1:0]    acc_sum, digit_r;
  logic [5:0]            key_sh;

  // Clamp configuration to usable ranges
  always_comb begin
    w_eff    = (window_q == '0) ? 16'd1 : window_q;
    mod_zero = (modulus_q == '0);
    if (hcount_q == '0) begin
      k_eff = 4'd1;
    end else if (32'(hcount_q) > MAX_HASHES) begin
      k_eff = 4'(MAX_HASHES);
    end else begin
      k_eff = hcount_q;
    end
    if (dims_q == '0) begin
      d_eff = CW'(1);
    end else if (32'(dims_q) > MAX_DIMENSIONS) begin
      d_eff = CW'(MAX_DIMENSIONS);
    end else begin
      d_eff = CW'(dims_q);
    end
  end

  // Grid numerator: floor((x - s*2^F) / 2^F), folded by ones' complement to a non-negative value for the divider
  always_comb begin
    num = $signed({x_q[CoordBits-1], x_q})
        - $signed({1'b0, CoordBits'(shift_rd_q) << FRACTION_BITS});
    t   = num >>> FRACTION_BITS;
    u   = t[NumW-1] ? ~t[CoordBits-1:0] : t[CoordBits-1:0];
  end

  // Digit from the remainder; negative grid index maps to M-1-r
  assign digit_r = neg_q ? (modulus_q - 1'b1 - div_rem) : div_rem;

  // Horner update: (h*m mod M + a) mod M
  always_comb begin
    sum = {1'b0, hm_q} + {1'b0, a_q};
    if (!mod_zero && (sum >= {1'b0, modulus_q})) begin
      sum = sum - {1'b0, modulus_q};
    end
    acc_sum = sum[KeyBits-1:0];
  end

  assign last_hash  = (32'(j_q) + 1 >= 32'(k_q));
  assign last_coord = (32'(count_q) + 1 >= 32'(d_eff));
  assign key_sh     = 6'((32'(k_q) - 1 - 32'(j_q)) * 32'(key_step(k_q)));
  assign accept     = in_valid_i && in_ready_o;
  assign load_ok    = (32'(hash_index_i) < MAX_HASHES)
                   && (32'(coord_index_i) < MAX_DIMENSIONS);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (command_i == CMD_COORD)) begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_SUB;
      S_SUB:   state_d = S_DIV_Q;
      S_DIV_Q: begin
        if (div_done) begin
          state_d = mod_zero ? S_MUL : S_MODQ;
        end
      end
      S_MODQ:  state_d = S_DIV_R;
      S_DIV_R: begin
        if (div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL:   state_d = S_RED;
      S_RED:   state_d = mod_zero ? S_ADD : S_DIV_P;
      S_DIV_P: begin
        if (div_done) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (!last_hash) begin
          state_d = S_READ;
        end else if (last_coord) begin
          state_d = S_KEY_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_KEY_RD:  state_d = S_KEY_ACC;
      S_KEY_ACC: state_d = last_hash ? S_EMIT : S_KEY_RD;
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o   = 1'b0;
    shift_we     = 1'b0;
    shift_re     = 1'b0;
    acc_re       = 1'b0;
    acc_we       = 1'b0;
    acc_clear    = 1'b0;
    div_start    = 1'b0;
    emit         = 1'b0;
    div_dividend = DivBits'(u);
    div_divisor  = KeyBits'(w_eff);
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        shift_we   = accept && (command_i == CMD_LOAD) && load_ok;
      end
      S_READ: begin
        shift_re = 1'b1;
        acc_re   = 1'b1;
      end
      S_SUB: div_start = 1'b1;
      S_MODQ: begin
        div_start    = 1'b1;
        div_dividend = div_quot;
        div_divisor  = modulus_q;
      end
      S_RED: begin
        div_start    = !mod_zero;
        div_dividend = prod_q;
        div_divisor  = modulus_q;
      end
      S_ADD:    acc_we = 1'b1;
      S_KEY_RD: acc_re = 1'b1;
      S_EMIT: begin
        emit      = !out_valid_q || out_ready_i;
        acc_clear = emit;
      end
      default: ;
    endcase
  end

  // State, configuration and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_q    <= 16'd4;
      modulus_q   <= 32'd256;
      mult_q      <= 32'd3;
      hcount_q    <= 4'd4;
      dims_q      <= 11'd128;
      count_q     <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WINDOW_WIDTH: window_q  <= cfg_data_i[15:0];
          CFG_MODULUS:      modulus_q <= cfg_data_i;
          CFG_MULTIPLIER:   mult_q    <= cfg_data_i;
          CFG_HASH_COUNT:   hcount_q  <= cfg_data_i[3:0];
          CFG_DIMENSIONS:   dims_q    <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      // Advance the hash index; wrap and count coordinates after the last hash
      if (state_q == S_IDLE) begin
        j_q <= '0;
      end else if (state_q == S_ADD) begin
        if (last_hash) begin
          j_q     <= '0;
          count_q <= last_coord ? '0 : count_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end else if (state_q == S_KEY_ACC) begin
        j_q <= j_q + 1'b1;
      end
      // Hold the key until the downstream takes it
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= coordinate_i;
      k_q <= k_eff;
      i_q <= (32'(count_q) >= MAX_DIMENSIONS) ? DW'(MAX_DIMENSIONS - 1) : DW'(count_q);
    end
    if (state_q == S_SUB) begin
      neg_q <= t[NumW-1];
    end
    if ((state_q == S_DIV_Q) && div_done && mod_zero) begin
      a_q <= neg_q ? ~div_quot[KeyBits-1:0] : div_quot[KeyBits-1:0];
    end
    if ((state_q == S_DIV_R) && div_done) begin
      a_q <= digit_r;
    end
    if (state_q == S_MUL) begin
      prod_q <= acc_rd * mult_q;
    end
    if ((state_q == S_RED) && mod_zero) begin
      hm_q <= prod_q[KeyBits-1:0];
    end
    if ((state_q == S_DIV_P) && div_done) begin
      hm_q <= div_rem;
    end
    if ((state_q == S_ADD) && last_hash) begin
      key_q <= '0;
    end else if (state_q == S_KEY_ACC) begin
      key_q <= key_q + KeyBits'(acc_rd << key_sh);
    end
    if (emit) begin
      pos_q <= key_q;
    end
  end

  // Shift table: write on load requests, registered read per hash
  always_ff @(posedge clk_i) begin
    if (shift_we) begin
      shift_mem[{HW'(hash_index_i), DW'(coord_index_i)}] <= shift_value_i;
    end
    if (shift_re) begin
      shift_rd_q <= shift_mem[{j_q[HW-1:0], i_q}];
    end
  end

  lghk_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  lghk_acc_bank #(
    .AddrW (HW)
  ) u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (acc_re),
    .raddr_i (j_q[HW-1:0]),
    .we_i    (acc_we),
    .waddr_i (j_q[HW-1:0]),
    .wdata_i (acc_sum),
    .clear_i (acc_clear),
    .rdata_o (acc_rd)
  );

  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;

endmodule
